>>> hw/rtl/b58_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b58_pkg
// shared types, constants and the alphabet mapping for the base58 encoder
// ----------------------------------------------------------------------------
package b58_pkg;

    localparam int MAX_BYTES_DEF  = 32;
    localparam int MAX_DIGITS_DEF = 45;

    localparam int DIGIT_W   = 6;
    localparam int CARRY_W   = 8;
    localparam int CHAR_W    = 7;
    localparam int CAP_W     = 7;
    localparam int CAP_LIMIT = 64;
    localparam int MAX_CHARS_RESET = 35;

    // reciprocal of 58 scaled by 2^20, exact for 14 bit dividends
    localparam int RECIP_58  = 18079;
    localparam int RECIP_SH  = 20;
    localparam int RADIX     = 58;

    localparam logic [CHAR_W-1:0] CHAR_ONE = 7'h31;

    // register index
    localparam logic REG_MAX_CHARS = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABSORB,
        S_PREFIX,
        S_DIGITS,
        S_CLEAR
    } state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_beat_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_char;
        logic              overflow;
    } char_beat_t;

    // data handed from one cell to the next one up
    typedef struct packed {
        logic               tok;
        logic [CARRY_W-1:0] carry;
        logic [DIGIT_W-1:0] digit;
        logic               used;
    } cell_link_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctl_t;

    function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {1'b0, d};
        if (d < 6'd9)
            b58_char = 7'h31 + dx;
        else if (d < 6'd17)
            b58_char = 7'h41 + dx - 7'd9;
        else if (d < 6'd22)
            b58_char = 7'h4A + dx - 7'd17;
        else if (d < 6'd33)
            b58_char = 7'h50 + dx - 7'd22;
        else if (d < 6'd44)
            b58_char = 7'h61 + dx - 7'd33;
        else
            b58_char = 7'h6D + dx - 7'd44;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/base58_byte_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base58_byte_encoder_core
// byte string to base58 text, one digit cell per base-58 digit
// ----------------------------------------------------------------------------
// row transit: each absorbed byte ripples through the cell row, one cell per
//   cycle; one byte is in flight at a time
// byte intake: a new byte is taken only after the wave leaves the top cell
// final byte: one '1' beat per cycle for the zero prefix while the output is
//   not stalled, then a row shift-out if a byte was nonzero, then a row clear
// reset: asynchronous, active low; digits zero, max_chars back to 35
module base58_byte_encoder_core
    import b58_pkg::*;
#(
    parameter int MAX_BYTES  = MAX_BYTES_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte beats in
    input  wire logic        byte_valid,
    output logic             byte_ready,
    input  wire byte_beat_t  byte_data,
    // character beats out
    output logic             char_valid,
    input  wire logic        char_ready,
    output char_beat_t       char_data,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int BTW = $clog2(MAX_BYTES + 1);
    localparam int SHW = $clog2(MAX_DIGITS);

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    logic [CAP_W-1:0] max_chars_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_chars_reg <= CAP_W'(MAX_CHARS_RESET);
        else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_CHARS)
            max_chars_reg <= pwdata[CAP_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MAX_CHARS)
            prdata = 32'(max_chars_reg);
    end

    // values above 64 act as 64
    logic [CAP_W-1:0] cap;
    assign cap = (max_chars_reg > CAP_W'(CAP_LIMIT)) ? CAP_W'(CAP_LIMIT) : max_chars_reg;

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [BTW-1:0]     bytes_reg, bytes_next;       // bytes absorbed this string
    logic [BTW-1:0]     zpc_reg, zpc_next;           // leading zero bytes
    logic               seen_reg, seen_next;         // a nonzero byte came in
    logic               dropped_reg, dropped_next;   // a byte was dropped
    logic               lastp_reg, lastp_next;       // final byte is in the row
    logic [CAP_W-1:0]   emit_reg, emit_next;         // characters emitted
    logic [SHW-1:0]     sh_reg, sh_next;             // shifts done in digit phase
    logic               started_reg, started_next;   // top used digit reached

    logic               out_valid_reg, out_valid_next;
    char_beat_t         out_data_reg, out_data_next;

    // ------------------------------------------------------------------
    // cell row: link[0] feeds cell 0, link[j+1] is the output of cell j
    // ------------------------------------------------------------------
    cell_link_t         link [MAX_DIGITS+1];
    cell_ctl_t          ctl;
    logic               launch;
    logic [MAX_DIGITS-1:0] tok_vec;

    assign link[0].tok   = launch;
    assign link[0].carry = byte_data.data_byte;
    assign link[0].digit = '0;
    assign link[0].used  = 1'b0;

    for (genvar j = 0; j < MAX_DIGITS; j++)
    begin : g_cell
        b58_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .base_used ((j == 0) ? 1'b1 : 1'b0),
            .link_in   (link[j]),
            .link_out  (link[j+1])
        );
        assign tok_vec[j] = link[j+1].tok;
    end

    cell_link_t top;
    assign top = link[MAX_DIGITS];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    logic   take;
    logic   room;
    logic   slot_free;
    logic   load;
    logic   is_last;
    logic   emitting;
    state_t emit_start;

    assign byte_ready = (state_reg == S_IDLE);
    assign take       = byte_valid && byte_ready;
    assign room       = (bytes_reg < BTW'(MAX_BYTES));
    assign slot_free  = !out_valid_reg || char_ready;
    assign emitting   = started_reg || top.used;

    // first phase of the output for this string
    always_comb
    begin
        if (cap == '0)
            emit_start = S_CLEAR;
        else if (zpc_reg != '0)
            emit_start = S_PREFIX;
        else if (seen_reg)
            emit_start = S_DIGITS;
        else
            emit_start = S_CLEAR;
    end

    always_comb
    begin
        state_next     = state_reg;
        bytes_next     = bytes_reg;
        zpc_next       = zpc_reg;
        seen_next      = seen_reg;
        dropped_next   = dropped_reg;
        lastp_next     = lastp_reg;
        emit_next      = emit_reg;
        sh_next        = sh_reg;
        started_next   = started_reg;
        out_data_next  = out_data_reg;
        launch         = 1'b0;
        load           = 1'b0;
        is_last        = 1'b0;
        ctl            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (room)
                    begin
                        // start a carry wave at cell 0
                        launch     = 1'b1;
                        bytes_next = bytes_reg + BTW'(1);
                        if (!seen_reg && byte_data.data_byte == 8'd0)
                            zpc_next = zpc_reg + BTW'(1);
                        else
                            seen_next = 1'b1;
                        lastp_next = byte_data.last_byte;
                        state_next = S_ABSORB;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                        if (byte_data.last_byte)
                            state_next = emit_start;
                    end
                end
            end

            S_ABSORB:
            begin
                // wave has left the top cell
                if (top.tok)
                    state_next = lastp_reg ? emit_start : S_IDLE;
            end

            S_PREFIX:
            begin
                if (slot_free)
                begin
                    load    = 1'b1;
                    is_last = (CAP_W'(emit_reg + CAP_W'(1)) == cap) ||
                              ((CAP_W'(emit_reg + CAP_W'(1)) == CAP_W'(zpc_reg)) && !seen_reg);
                    out_data_next.out_char  = CHAR_ONE;
                    out_data_next.last_char = is_last;
                    out_data_next.overflow  = dropped_reg;
                    emit_next = emit_reg + CAP_W'(1);
                    if (is_last)
                        state_next = S_CLEAR;
                    else if (CAP_W'(emit_reg + CAP_W'(1)) == CAP_W'(zpc_reg))
                        state_next = S_DIGITS;
                end
            end

            S_DIGITS:
            begin
                // leading unused cells shift past without a beat
                if (!emitting || slot_free)
                begin
                    ctl.shift = 1'b1;
                    sh_next   = sh_reg + SHW'(1);
                    if (emitting)
                    begin
                        load         = 1'b1;
                        started_next = 1'b1;
                        is_last = (CAP_W'(emit_reg + CAP_W'(1)) == cap) ||
                                  (sh_reg == SHW'(MAX_DIGITS - 1));
                        out_data_next.out_char  = b58_char(top.digit);
                        out_data_next.last_char = is_last;
                        out_data_next.overflow  = dropped_reg;
                        emit_next = emit_reg + CAP_W'(1);
                        if (is_last)
                            state_next = S_CLEAR;
                    end
                end
            end

            S_CLEAR:
            begin
                ctl.clear    = 1'b1;
                bytes_next   = '0;
                zpc_next     = '0;
                seen_next    = 1'b0;
                dropped_next = 1'b0;
                lastp_next   = 1'b0;
                emit_next    = '0;
                sh_next      = '0;
                started_next = 1'b0;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
            out_valid_next = 1'b1;
        else if (char_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bytes_reg     <= '0;
            zpc_reg       <= '0;
            seen_reg      <= 1'b0;
            dropped_reg   <= 1'b0;
            lastp_reg     <= 1'b0;
            emit_reg      <= '0;
            sh_reg        <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bytes_reg     <= bytes_next;
            zpc_reg       <= zpc_next;
            seen_reg      <= seen_next;
            dropped_reg   <= dropped_next;
            lastp_reg     <= lastp_next;
            emit_reg      <= emit_next;
            sh_reg        <= sh_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // character beat payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign char_valid = out_valid_reg;
    assign char_data  = out_data_reg;

`ifndef SYNTHESIS
    // only one carry wave travels the row at a time
    a_one_wave: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one carry wave in the cell row");

    // a wave only leaves the top cell while the sequencer waits for it
    a_wave_in_absorb: assert property (@(posedge clk) disable iff (!rst_n)
        top.tok |-> state_reg == S_ABSORB)
        else $error("carry wave finished outside absorb");

    // never more characters than the cap allows
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg <= cap)
        else $error("emitted characters exceed max_chars");

    // absorbed byte count stays within the limit
    a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_reg <= BTW'(MAX_BYTES))
        else $error("absorbed bytes exceed the limit");

    // a beat marked last is followed by the row clear
    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (load && is_last) |=> state_reg == S_CLEAR)
        else $error("final character not followed by clear");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/b58_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b58_cell
// one base-58 digit of the running number: times 256 plus carry, or shift up
// ----------------------------------------------------------------------------
module b58_cell
    import b58_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctl_t  ctl,
    input  wire logic       base_used,
    input  wire cell_link_t link_in,
    output cell_link_t      link_out
);

    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               used_reg, used_next;
    logic               tok_reg;
    logic [CARRY_W-1:0] carry_reg, carry_next;

    logic [13:0] v;
    logic [28:0] prod;
    logic [CARRY_W-1:0] q;
    logic [13:0] rem;

    // digit*256 + carry is a plain concatenation
    assign v    = {digit_reg, link_in.carry};
    assign prod = 29'(v) * 29'(RECIP_58);
    assign q    = prod[RECIP_SH+CARRY_W-1:RECIP_SH];
    assign rem  = v - 14'(q) * 14'(RADIX);

    always_comb
    begin
        digit_next = digit_reg;
        used_next  = used_reg;
        carry_next = carry_reg;
        if (ctl.clear)
        begin
            digit_next = '0;
            used_next  = base_used;
        end
        else if (ctl.shift)
        begin
            digit_next = link_in.digit;
            used_next  = link_in.used;
        end
        else if (link_in.tok)
        begin
            digit_next = rem[DIGIT_W-1:0];
            used_next  = used_reg | (rem[DIGIT_W-1:0] != '0);
            carry_next = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
            used_reg  <= base_used;
            tok_reg   <= 1'b0;
        end
        else
        begin
            digit_reg <= digit_next;
            used_reg  <= used_next;
            tok_reg   <= link_in.tok & ~ctl.clear & ~ctl.shift;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
    end

    assign link_out.tok   = tok_reg;
    assign link_out.carry = carry_reg;
    assign link_out.digit = digit_reg;
    assign link_out.used  = used_reg;

endmodule
`default_nettype wire
